>>> hdl/dmcc_pkg.sv
// Package for the MESI directory cache controller: geometry constants,
// item types, state codes and controller state. No dependencies.
package dmcc_pkg;

  localparam int SET_BITS   = 6;
  localparam int BLOCK_BITS = 6;
  localparam int WAYS       = 4;
  localparam int NUM_CACHES = 8;

  localparam int NUM_SETS  = 1 << SET_BITS;
  localparam int TAG_BITS  = 32 - SET_BITS - BLOCK_BITS;
  localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
  // tag (TAG_BITS) + stamp (32) + mesi (2) + filled (1) per way
  localparam int LINE_BITS = TAG_BITS + 32 + 2 + 1;
  localparam int ROW_BITS  = LINE_BITS * WAYS;
  localparam int KEEP_BITS = (NUM_CACHES >= 8) ? 8 : NUM_CACHES;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_BUSRD  = 2'd2,
    OP_BUSRDX = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_t;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_READ  = 2'd1;
  localparam logic [1:0] DIR_WRITE = 2'd2;
  localparam logic [1:0] SNP_NONE  = 2'd0;
  localparam logic [1:0] SNP_RD    = 2'd1;
  localparam logic [1:0] SNP_RDX   = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] time_stamp;
    logic [7:0]  sharer_mask;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [5:0]  victim_set;
    logic [19:0] victim_tag;
    logic [1:0]  dir_request;
    logic [1:0]  snoop_kind;
    logic [7:0]  snoop_targets;
    logic        flush;
    logic        invalidated;
    logic [1:0]  line_state_out;
  } out_item_t;

  typedef struct packed {
    logic          filled;
    mesi_t         mesi;
    logic [31:0]   stamp;
    logic [TAG_BITS-1:0] tag;
  } line_t;

  typedef enum logic [1:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_UPDATE,
    CS_HOLD
  } ctrl_state_t;

endpackage

>>> hdl/directory_mesi_cache_controller_unit.sv
// Top level of the MESI directory cache controller. Depends on dmcc_pkg,
// dmcc_ram and dmcc_logic.
// Per item, the row memory does a read-modify-write: the set row is read, then UPDATE
// writes the new row and registers the result; no new item is accepted until it is taken.
// Reset: a clearing pass over all 2^SET_BITS sets (64) empties every set; no item
// is accepted until it ends.
module directory_mesi_cache_controller_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dmcc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dmcc_pkg::out_item_t  out_data
);
  import dmcc_pkg::*;

  ctrl_state_t           state;
  ctrl_state_t           state_next;
  logic [SET_BITS-1:0]   clr_cnt;
  in_item_t              item;
  logic [ROW_BITS-1:0]   row;
  logic [ROW_BITS-1:0]   row_new;
  out_item_t             res;
  logic                  we;
  logic [SET_BITS-1:0]   waddr;
  logic [ROW_BITS-1:0]   wdata;
  logic [SET_BITS-1:0]   in_set;
  logic                  accept;

  assign in_set = in_data.address[BLOCK_BITS +: SET_BITS];
  assign accept = in_valid && in_ready;

  dmcc_ram #(.WIDTH(ROW_BITS), .DEPTH(NUM_SETS)) u_rows (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(in_set),
    .rdata(row)
  );

  dmcc_logic u_logic (
    .item   (item),
    .row    (row),
    .row_new(row_new),
    .res    (res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      CS_CLEAR:  if (clr_cnt == SET_BITS'(NUM_SETS - 1)) state_next = CS_IDLE;
      CS_IDLE:   if (accept) state_next = CS_UPDATE;
      CS_UPDATE: state_next = CS_HOLD;
      CS_HOLD:   if (out_ready) state_next = accept ? CS_UPDATE : CS_IDLE;
      default:   state_next = CS_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    we = 1'b0;
    waddr = item.address[BLOCK_BITS +: SET_BITS];
    wdata = row_new;
    unique case (state)
      CS_CLEAR: begin
        we = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
      end
      CS_IDLE:   in_ready = 1'b1;
      CS_UPDATE: we = 1'b1;
      CS_HOLD:   in_ready = out_ready;
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == CS_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == CS_UPDATE) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (state == CS_UPDATE) begin
      out_data <= res;
    end
  end

endmodule

>>> hdl/dmcc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dmcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/dmcc_logic.sv
// Per-item coherence logic: lookup, victim choice and MESI transition on one set row.
// Depends on dmcc_pkg.
module dmcc_logic (
  input  dmcc_pkg::in_item_t             item,
  input  logic [dmcc_pkg::ROW_BITS-1:0]  row,
  output logic [dmcc_pkg::ROW_BITS-1:0]  row_new,
  output dmcc_pkg::out_item_t            res
);
  import dmcc_pkg::*;

  line_t                lines [WAYS];
  logic [TAG_BITS-1:0]  tag;
  logic [7:0]           sharers;
  logic                 found;
  logic [WAY_BITS-1:0]  fway;
  logic                 empty_found;
  logic [WAY_BITS-1:0]  eway;
  logic [WAY_BITS-1:0]  lru;
  logic [WAY_BITS-1:0]  way;
  line_t                cur;
  line_t                upd;
  mesi_t                st;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      lines[w] = row[w*LINE_BITS +: LINE_BITS];
    end
  end

  assign tag = item.address[31 -: TAG_BITS];
  assign sharers = item.sharer_mask & 8'((9'd1 << KEEP_BITS) - 9'd1);

  always_comb begin
    found = 1'b0;
    fway = '0;
    empty_found = 1'b0;
    eway = '0;
    lru = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (lines[w].filled && lines[w].tag == tag) begin
        found = 1'b1;
        fway = WAY_BITS'(w);
      end
      if (!lines[w].filled) begin
        empty_found = 1'b1;
        eway = WAY_BITS'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (lines[w].stamp < lines[lru].stamp) begin
        lru = WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    res = '0;
    row_new = row;
    way = found ? fway : (empty_found ? eway : lru);
    cur = lines[way];
    upd = cur;
    st = cur.mesi;
    if (item.opcode[1]) begin
      if (found && cur.mesi != ST_I) begin
        res.flush = (cur.mesi == ST_M);
        if (item.opcode == OP_BUSRD) begin
          upd.mesi = ST_S;
        end else begin
          res.invalidated = 1'b1;
          upd.mesi = ST_I;
        end
        res.line_state_out = upd.mesi;
      end
    end else begin
      if (found) begin
        res.hit = (cur.mesi != ST_I);
      end else if (cur.filled) begin
        res.evicted = 1'b1;
        res.victim_set = 6'(item.address[BLOCK_BITS +: SET_BITS]);
        res.victim_tag = 20'(cur.tag);
        st = ST_I;
      end else begin
        st = ST_I;
      end
      upd.tag = tag;
      upd.filled = 1'b1;
      upd.stamp = item.time_stamp;
      upd.mesi = st;
      if (item.opcode == OP_LOAD) begin
        if (st == ST_I) begin
          res.dir_request = DIR_READ;
          if (sharers == 8'd0) begin
            upd.mesi = ST_E;
          end else begin
            upd.mesi = ST_S;
            res.snoop_kind = SNP_RD;
            res.snoop_targets = sharers;
          end
        end
      end else begin
        if (st == ST_I || st == ST_S) begin
          res.dir_request = DIR_WRITE;
          if (sharers != 8'd0) begin
            res.snoop_kind = SNP_RDX;
            res.snoop_targets = sharers;
          end
        end else if (st == ST_E) begin
          res.dir_request = DIR_WRITE;
        end
        upd.mesi = ST_M;
      end
      res.line_state_out = upd.mesi;
    end
    row_new[way*LINE_BITS +: LINE_BITS] = upd;
  end

endmodule

>>> hdl/dmcc_checker.sv
// Port-level checker for the MESI directory cache controller, bound to the top.
// Depends on dmcc_pkg.
module dmcc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input dmcc_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input dmcc_pkg::out_item_t out_data
);
  import dmcc_pkg::*;

  // accepted item yields a result once its UPDATE state has passed
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("result missing after accept");

  // no accept in the cycle right after an accept
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back accept");

  // snoop results that flush or invalidate never report hits, evictions or directory traffic
  a_snp: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.flush || out_data.invalidated) |->
      !out_data.hit && !out_data.evicted && out_data.dir_request == DIR_NONE)
    else $error("snoop result carries local fields");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind directory_mesi_cache_controller_unit dmcc_checker u_dmcc_checker (.*);

>>> tb/sv/testbench.sv
// Testbench for the MESI directory cache controller: random and directed
// loads, stores and snoops, checked against an in-bench cache model.
// Depends on dmcc_pkg and directory_mesi_cache_controller_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dmcc_pkg::*;

  localparam int NLINES = NUM_SETS * WAYS;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  directory_mesi_cache_controller_unit u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  logic [TAG_BITS-1:0] mdl_tag [NLINES];
  logic                mdl_filled [NLINES];
  mesi_t               mdl_mesi [NLINES];
  logic [31:0]         mdl_stamp [NLINES];

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  stim_done = 0;
  bit  hold_receiver = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  in_ready_seen = 0;
  int  long_hold = 0;

  // Six hot tags shared by all sets so lines get reused, hit and evicted.
  logic [TAG_BITS-1:0] hot_tags [6];

  function automatic out_item_t predict_access(in_item_t it);
    out_item_t r;
    logic [SET_BITS-1:0] set;
    logic [TAG_BITS-1:0] tag;
    logic [7:0] sh;
    int way, idx, best;
    mesi_t st;
    r = '0;
    set = it.address[BLOCK_BITS +: SET_BITS];
    tag = it.address[31 -: TAG_BITS];
    sh = it.sharer_mask & 8'((1 << KEEP_BITS) - 1);
    way = -1;
    for (int w = 0; w < WAYS; w++)
      if (way < 0 && mdl_filled[set*WAYS+w] && mdl_tag[set*WAYS+w] == tag) way = w;
    if (it.opcode == OP_BUSRD || it.opcode == OP_BUSRDX) begin
      if (way < 0) return r;
      idx = set*WAYS + way;
      if (mdl_mesi[idx] == ST_I) return r;
      r.flush = (mdl_mesi[idx] == ST_M);
      if (it.opcode == OP_BUSRD) begin
        mdl_mesi[idx] = ST_S;
      end else begin
        r.invalidated = 1'b1;
        mdl_mesi[idx] = ST_I;
      end
      r.line_state_out = mdl_mesi[idx];
      return r;
    end
    if (way >= 0) begin
      idx = set*WAYS + way;
      r.hit = (mdl_mesi[idx] != ST_I);
    end else begin
      best = -1;
      for (int w = 0; w < WAYS; w++)
        if (best < 0 && !mdl_filled[set*WAYS+w]) best = w;
      if (best < 0) begin
        best = 0;
        for (int w = 1; w < WAYS; w++)
          if (mdl_stamp[set*WAYS+w] < mdl_stamp[set*WAYS+best]) best = w;
      end
      idx = set*WAYS + best;
      if (mdl_filled[idx]) begin
        r.evicted = 1'b1;
        r.victim_set = 6'(set);
        r.victim_tag = 20'(mdl_tag[idx]);
        mdl_mesi[idx] = ST_I;
      end
    end
    mdl_tag[idx] = tag;
    mdl_filled[idx] = 1'b1;
    mdl_stamp[idx] = it.time_stamp;
    st = mdl_mesi[idx];
    if (it.opcode == OP_LOAD) begin
      if (st == ST_I) begin
        r.dir_request = DIR_READ;
        if (sh == 0) begin
          mdl_mesi[idx] = ST_E;
        end else begin
          mdl_mesi[idx] = ST_S;
          r.snoop_kind = SNP_RD;
          r.snoop_targets = sh;
        end
      end
    end else begin
      if (st == ST_I || st == ST_S) begin
        r.dir_request = DIR_WRITE;
        if (sh != 0) begin
          r.snoop_kind = SNP_RDX;
          r.snoop_targets = sh;
        end
      end else if (st == ST_E) begin
        r.dir_request = DIR_WRITE;
      end
      mdl_mesi[idx] = ST_M;
    end
    r.line_state_out = mdl_mesi[idx];
    return r;
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, logic [TAG_BITS-1:0] tag,
                                         logic [SET_BITS-1:0] set, logic [31:0] ts,
                                         logic [7:0] sh);
    in_item_t it;
    it.opcode = op;
    it.address = {tag, set, BLOCK_BITS'($urandom)};
    it.time_stamp = ts;
    it.sharer_mask = sh;
    return it;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_item_t it;
    for (int i = 0; i < 6; i++) hot_tags[i] = TAG_BITS'($urandom);
    hot_tags[0] = '0;
    hot_tags[1] = '1;
    rst = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // Directed: miss to E, store E->M, snoops on M, I-tag reuse, eviction.
    pending_items.push_back(make_item(OP_LOAD, '0, '0, 32'd0, 8'h00));
    pending_items.push_back(make_item(OP_STORE, '0, '0, 32'd5, 8'hFF));
    pending_items.push_back(make_item(OP_BUSRD, '0, '0, 32'd0, 8'h00));
    pending_items.push_back(make_item(OP_STORE, '0, '0, 32'd6, 8'hA5));
    pending_items.push_back(make_item(OP_BUSRDX, '0, '0, 32'd0, 8'h00));
    pending_items.push_back(make_item(OP_BUSRDX, '0, '0, 32'd0, 8'h00));
    pending_items.push_back(make_item(OP_LOAD, '0, '0, 32'hFFFF_FFFF, 8'hFF));
    pending_items.push_back(make_item(OP_BUSRD, '1, '1, 32'd0, 8'hFF));
    pending_items.push_back(make_item(OP_STORE, '1, '1, 32'd1, 8'h00));
    for (int w = 0; w < WAYS + 2; w++)
      pending_items.push_back(make_item(OP_LOAD, TAG_BITS'(w + 2), '1, 32'(w), 8'h0F));
    pending_items.push_back(make_item(OP_STORE, '1, '1, 32'd9, 8'h55));
    pending_items.push_back(make_item(OP_LOAD, 20'h12345, 6'h2A, 32'hFFFF_FFFF, 8'h80));
    pending_items.push_back(make_item(OP_STORE, 20'h12345, 6'h2A, 32'd0, 8'h00));
    // Random: hot tags in a few sets, some fully random noise.
    for (int i = 0; i < 700; i++) begin
      if ($urandom_range(0, 9) == 0)
        it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom}));
      else
        it = make_item(2'($urandom), hot_tags[$urandom_range(0, 5)],
                       SET_BITS'($urandom_range(0, 3)) ^ {SET_BITS{i[0] & i[5]}},
                       $urandom, 8'($urandom_range(0, 3) == 0 ? 0 : $urandom));
      pending_items.push_back(it);
      if (i == 200) begin
        wait (pending_items.size() == 0);
        hold_receiver = 1;
        for (int k = 0; k < 30; k++)
          pending_items.push_back(make_item(2'($urandom), hot_tags[k % 6], '0,
                                            $urandom, 8'($urandom)));
        wait (pending_items.size() == 0);
        @(posedge clk);
        wait (!in_valid);
        wait (expected_results.size() == 0);
        @(negedge clk);
      end
    end
    wait (pending_items.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    stim_done = 1;
  end

  // Driver: present items at the falling edge, hold until accepted.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
      in_data <= '0;
    end else if (!in_valid || in_ready_seen) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1;
        gap_left <= pick_gap();
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_ready_seen <= (!rst && in_valid && in_ready);
    if (!rst && in_valid && in_ready) begin
      expected_results.push_back(predict_access(in_data));
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        error_count <= error_count + 1;
      end else if (expected_results[0] !== out_data) begin
        $display("%0t: mismatch expected %p actual %p", $time, expected_results[0],
                 out_data);
        error_count <= error_count + 1;
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (hold_receiver && long_hold < 300) begin
      long_hold <= long_hold + 1;
      out_ready <= 0;
      if (long_hold == 299) hold_receiver <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  initial begin
    for (int i = 0; i < NLINES; i++) begin
      mdl_filled[i] = 0;
      mdl_mesi[i] = ST_I;
      mdl_tag[i] = '0;
      mdl_stamp[i] = '0;
    end
    fork
      begin
        wait (stim_done && expected_results.size() == 0);
        repeat (20) @(posedge clk);
      end
      wait (cycle_count >= CYCLE_LIMIT);
    join_any
    if (cycle_count >= CYCLE_LIMIT || expected_results.size() != 0) begin
      $display("RESULT: ERROR");
    end else if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
